// ----- rtl/core/hslrgb_pkg.sv -----
`default_nettype none

package hslrgb_pkg;

	// default fraction bits of the hue, saturation and lightness fields
	localparam int FRAC_BITS_DEF = 12;

	// channel width and lane layout
	localparam int CH_W = 8;
	localparam int LANES = 3;
	localparam int LANE_R = 0;
	localparam int LANE_G = 1;
	localparam int LANE_B = 2;

	localparam logic [CH_W-1:0] CH_MAX = 8'd255;

	// palette cube: four levels per axis, levels picked by channel / 85
	localparam logic [CH_W-1:0] LEVEL_STEP = 8'd85;
	localparam logic [CH_W-1:0] LEVEL_TWO = 8'd170;
	localparam logic [CH_W-1:0] PAL_BASE = 8'd16;
	localparam logic [CH_W-1:0] PAL_R_STEP = 8'd36;
	localparam logic [CH_W-1:0] PAL_G_STEP = 8'd6;

	// channel / 85 for an 8-bit channel
	function automatic logic [1:0] level_of(input logic [CH_W-1:0] c);
		logic [1:0] lv;
		if (c == CH_MAX) begin
			lv = 2'd3;
		end else if (c >= LEVEL_TWO) begin
			lv = 2'd2;
		end else if (c >= LEVEL_STEP) begin
			lv = 2'd1;
		end else begin
			lv = 2'd0;
		end
		return lv;
	endfunction

	function automatic logic [CH_W-1:0] palette_of(
		input logic [CH_W-1:0] r,
		input logic [CH_W-1:0] g,
		input logic [CH_W-1:0] b
	);
		logic [CH_W-1:0] lr;
		logic [CH_W-1:0] lg;
		logic [CH_W-1:0] lb;
		lr = {6'd0, level_of(r)};
		lg = {6'd0, level_of(g)};
		lb = {6'd0, level_of(b)};
		return PAL_BASE + CH_W'(PAL_R_STEP * lr) + CH_W'(PAL_G_STEP * lg) + lb;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hslrgb_hsl_if.sv -----
`default_nettype none

interface hslrgb_hsl_if
	import hslrgb_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [FRAC_BITS-1:0] hue;
	logic [FRAC_BITS:0]   saturation;
	logic [FRAC_BITS:0]   lightness;

	modport source (output valid, output hue, output saturation, output lightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input lightness,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/core/hslrgb_rgb_if.sv -----
`default_nettype none

interface hslrgb_rgb_if
	import hslrgb_pkg::*;
;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;
	logic [CH_W-1:0] palette_index;

	modport source (output valid, output red, output green, output blue,
		output palette_index, input ready);
	modport sink (input valid, input red, input green, input blue,
		input palette_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/hslrgb_front.sv -----
`default_nettype none

module hslrgb_front
	import hslrgb_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   up_valid,
	output logic                        up_ready,
	input  wire logic [FRAC_BITS-1:0]   hue,
	input  wire logic [FRAC_BITS:0]     saturation,
	input  wire logic [FRAC_BITS:0]     lightness,
	output logic                        dn_valid,
	input  wire logic                   dn_ready,
	output logic [2*FRAC_BITS:0]        pq,
	output logic [2*FRAC_BITS:0]        dq,
	output logic [FRAC_BITS:0]          w [LANES]
);
	localparam int SW = FRAC_BITS + 1;
	localparam int PW = 2 * FRAC_BITS + 1;
	localparam int QW = PW + 1;
	localparam int POS_W = FRAC_BITS + 2;
	localparam int WW = FRAC_BITS + 1;
	localparam int ONE = 1 << FRAC_BITS;

	// ramp weight in units of 1/ONE for a position in thirds of 1/ONE
	function automatic logic [WW-1:0] ramp_weight(input logic [POS_W-1:0] pos);
		logic [POS_W:0] pos2;
		logic [WW-1:0]  wt;
		pos2 = {pos, 1'b0};
		if (pos2 < (POS_W+1)'(ONE)) begin
			wt = WW'(pos2);
		end else if (pos2 < (POS_W+1)'(3 * ONE)) begin
			wt = WW'(ONE);
		end else if (pos < POS_W'(2 * ONE)) begin
			wt = WW'((POS_W+1)'(4 * ONE) - pos2);
		end else begin
			wt = '0;
		end
		return wt;
	endfunction

	logic [SW-1:0]    s_c;
	logic [SW-1:0]    l_c;
	logic [2*SW-1:0]  ls_c;
	logic [POS_W-1:0] h3;
	logic [POS_W-1:0] pos [LANES];

	logic             v_s1;
	logic [SW-1:0]    s_s1;
	logic [SW-1:0]    l_s1;
	logic [PW-1:0]    ls_s1;
	logic [WW-1:0]    w_s1 [LANES];

	logic [QW-1:0]    qq_c;
	logic [QW-1:0]    pq_c;
	logic [QW-1:0]    dq_c;

	logic             v_s2;
	logic [PW-1:0]    pq_s2;
	logic [PW-1:0]    dq_s2;
	logic [WW-1:0]    w_s2 [LANES];

	logic             en_s1;
	logic             en_s2;

	assign en_s2 = !v_s2 || dn_ready;
	assign en_s1 = !v_s1 || en_s2;
	assign up_ready = en_s1;

	// stage 1: clamp, l*s, hue positions and ramp weights
	always_comb begin
		s_c = (saturation > SW'(ONE)) ? SW'(ONE) : saturation;
		l_c = (lightness > SW'(ONE)) ? SW'(ONE) : lightness;
		ls_c = (2*SW)'(s_c) * (2*SW)'(l_c);
		h3 = (POS_W'(hue) << 1) + POS_W'(hue);
		pos[LANE_R] = h3 + POS_W'(ONE);
		if (pos[LANE_R] >= POS_W'(3 * ONE)) begin
			pos[LANE_R] = pos[LANE_R] - POS_W'(3 * ONE);
		end
		pos[LANE_G] = h3;
		pos[LANE_B] = (h3 >= POS_W'(ONE)) ? h3 - POS_W'(ONE) : h3 + POS_W'(2 * ONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && up_valid) begin
			s_s1 <= s_c;
			l_s1 <= l_c;
			ls_s1 <= ls_c[PW-1:0];
			for (int i = 0; i < LANES; i++) begin
				w_s1[i] <= ramp_weight(pos[i]);
			end
		end
	end

	// stage 2: q and p with 2*FRAC_BITS fraction bits
	always_comb begin
		if ({l_s1, 1'b0} < (SW+1)'(ONE)) begin
			qq_c = (QW'(l_s1) << FRAC_BITS) + QW'(ls_s1);
		end else begin
			qq_c = ((QW'(l_s1) + QW'(s_s1)) << FRAC_BITS) - QW'(ls_s1);
		end
		pq_c = (QW'(l_s1) << (FRAC_BITS + 1)) - qq_c;
		dq_c = qq_c - pq_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			pq_s2 <= pq_c[PW-1:0];
			dq_s2 <= dq_c[PW-1:0];
			w_s2 <= w_s1;
		end
	end

	assign dn_valid = v_s2;
	assign pq = pq_s2;
	assign dq = dq_s2;
	assign w = w_s2;

endmodule

`default_nettype wire

// ----- rtl/core/hslrgb_ramp.sv -----
`default_nettype none

module hslrgb_ramp
	import hslrgb_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 up_valid,
	output logic                      up_ready,
	input  wire logic [2*FRAC_BITS:0] pq,
	input  wire logic [2*FRAC_BITS:0] dq,
	input  wire logic [FRAC_BITS:0]   w [LANES],
	output logic                      dn_valid,
	input  wire logic                 dn_ready,
	output logic [CH_W-1:0]           ch [LANES]
);
	localparam int PW = 2 * FRAC_BITS + 1;
	localparam int WW = FRAC_BITS + 1;
	localparam int VW = PW + WW;
	localparam int NW = VW + CH_W;
	localparam int RW = NW - 3 * FRAC_BITS;

	logic            v_s3;
	logic [PW-1:0]   pq_s3;
	logic [VW-1:0]   prod_s3 [LANES];

	logic [VW-1:0]   val_c [LANES];
	logic [NW-1:0]   num_c [LANES];
	logic [RW-1:0]   res_c [LANES];

	logic            v_s4;
	logic [CH_W-1:0] ch_s4 [LANES];

	logic            en_s3;
	logic            en_s4;

	assign en_s4 = !v_s4 || dn_ready;
	assign en_s3 = !v_s3 || en_s4;
	assign up_ready = en_s3;

	// stage 3: (q - p) times the ramp weight, one multiplier per lane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && up_valid) begin
			pq_s3 <= pq;
			for (int i = 0; i < LANES; i++) begin
				prod_s3[i] <= VW'(dq) * VW'(w[i]);
			end
		end
	end

	// stage 4: add p, scale by 255, round half up, saturate
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			val_c[i] = (VW'(pq_s3) << FRAC_BITS) + prod_s3[i];
			num_c[i] = (NW'(val_c[i]) << CH_W) - NW'(val_c[i])
				+ (NW'(1) << (3 * FRAC_BITS - 1));
			res_c[i] = num_c[i][NW-1:3*FRAC_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			for (int i = 0; i < LANES; i++) begin
				ch_s4[i] <= (res_c[i] > RW'(CH_MAX)) ? CH_MAX : res_c[i][CH_W-1:0];
			end
		end
	end

	assign dn_valid = v_s4;
	assign ch = ch_s4;

endmodule

`default_nettype wire

// ----- rtl/core/hslrgb_palette.sv -----
`default_nettype none

module hslrgb_palette
	import hslrgb_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            up_valid,
	output logic                 up_ready,
	input  wire logic [CH_W-1:0] ch [LANES],
	output logic                 dn_valid,
	input  wire logic            dn_ready,
	output logic [CH_W-1:0]      red,
	output logic [CH_W-1:0]      green,
	output logic [CH_W-1:0]      blue,
	output logic [CH_W-1:0]      palette_index
);
	logic            v_s5;
	logic [CH_W-1:0] red_s5;
	logic [CH_W-1:0] green_s5;
	logic [CH_W-1:0] blue_s5;
	logic [CH_W-1:0] pal_s5;
	logic            en_s5;

	assign en_s5 = !v_s5 || dn_ready;
	assign up_ready = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en_s5) begin
			v_s5 <= up_valid;
		end
	end

	// output register, also holds the word while the sink stalls
	always_ff @(posedge clk) begin
		if (en_s5 && up_valid) begin
			red_s5 <= ch[LANE_R];
			green_s5 <= ch[LANE_G];
			blue_s5 <= ch[LANE_B];
			pal_s5 <= palette_of(ch[LANE_R], ch[LANE_G], ch[LANE_B]);
		end
	end

	assign dn_valid = v_s5;
	assign red = red_s5;
	assign green = green_s5;
	assign blue = blue_s5;
	assign palette_index = pal_s5;

endmodule

`default_nettype wire

// ----- rtl/core/hsl_to_rgb_palette_converter.sv -----
`default_nettype none

// hsl to rgb pixel converter with a 256-color terminal palette index. each input
// word is one pixel (hue, saturation, lightness in unsigned fixed point with
// FRAC_BITS fraction bits; saturation and lightness above one are taken as one);
// each output word is 8-bit red, green, blue rounded half up and the palette index
// 16 + 36*(r/85) + 6*(g/85) + b/85. the block is a five-stage pipeline that takes
// one pixel every clock while the sink does not stall; the rate is set by the single
// lane multiplier per channel in stage 3, which is fully pipelined. every stage with
// no valid word is refilled even while the sink stalls, so ready stays high until
// the whole pipeline is full. there is no configuration and no state beyond the
// pipeline registers.

module hsl_to_rgb_palette_converter
	import hslrgb_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	hslrgb_hsl_if.sink hsl,
	hslrgb_rgb_if.source rgb
);
	// q - p and p carry 2*FRAC_BITS fraction bits, weights are in units of 1/ONE
	logic                   front_valid;
	logic                   front_ready;
	logic [2*FRAC_BITS:0]   front_pq;
	logic [2*FRAC_BITS:0]   front_dq;
	logic [FRAC_BITS:0]     front_w [LANES];

	logic                   ramp_valid;
	logic                   ramp_ready;
	logic [CH_W-1:0]        ramp_ch [LANES];

	// stages 1 and 2: clamp, l*s, hue positions, q and p
	hslrgb_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (hsl.valid),
		.up_ready   (hsl.ready),
		.hue        (hsl.hue),
		.saturation (hsl.saturation),
		.lightness  (hsl.lightness),
		.dn_valid   (front_valid),
		.dn_ready   (front_ready),
		.pq         (front_pq),
		.dq         (front_dq),
		.w          (front_w)
	);

	// stages 3 and 4: ramp value per channel, scaled to 8 bits
	hslrgb_ramp #(
		.FRAC_BITS(FRAC_BITS)
	) u_ramp (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (front_valid),
		.up_ready (front_ready),
		.pq       (front_pq),
		.dq       (front_dq),
		.w        (front_w),
		.dn_valid (ramp_valid),
		.dn_ready (ramp_ready),
		.ch       (ramp_ch)
	);

	// stage 5: palette index and output register
	hslrgb_palette u_palette (
		.clk           (clk),
		.arst_n        (arst_n),
		.up_valid      (ramp_valid),
		.up_ready      (ramp_ready),
		.ch            (ramp_ch),
		.dn_valid      (rgb.valid),
		.dn_ready      (rgb.ready),
		.red           (rgb.red),
		.green         (rgb.green),
		.blue          (rgb.blue),
		.palette_index (rgb.palette_index)
	);

endmodule

`default_nettype wire

// ----- tb/hslrgb_checker.sv -----
`default_nettype none

module hslrgb_checker
	import hslrgb_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	hslrgb_hsl_if    hsl,
	hslrgb_rgb_if    rgb,
	output int       fail_count,
	output int       pending,
	output int       words_checked
);

	localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] palette_index;
	} pixel_rgb_t;

	pixel_rgb_t expected_px_q[$];
	int fails;
	int checked;

	// one channel of the hue ramp, pos in units of 1/(3*ONE)
	function automatic logic [CH_W-1:0] ramp_level(
		input longint unsigned p2,
		input longint unsigned q2,
		input longint unsigned pos
	);
		longint unsigned w;
		longint unsigned acc;
		if (2 * pos < ONE) begin
			w = 2 * pos;
		end else if (2 * pos < 3 * ONE) begin
			w = ONE;
		end else if (pos < 2 * ONE) begin
			w = 4 * ONE - 2 * pos;
		end else begin
			w = 0;
		end
		acc = (p2 * ONE + (q2 - p2) * w) * 255 + (64'd1 << (3 * FRAC_BITS - 1));
		acc = acc >> (3 * FRAC_BITS);
		return (acc > 255) ? CH_MAX : acc[CH_W-1:0];
	endfunction

	function automatic pixel_rgb_t predict_pixel(
		input logic [FRAC_BITS-1:0] h_in,
		input logic [FRAC_BITS:0]   s_in,
		input logic [FRAC_BITS:0]   l_in
	);
		longint unsigned h;
		longint unsigned s;
		longint unsigned l;
		longint unsigned q2;
		longint unsigned p2;
		longint unsigned h3;
		longint unsigned pos_r;
		longint unsigned pos_b;
		pixel_rgb_t px;
		h = 64'(h_in);
		s = (64'(s_in) > ONE) ? ONE : 64'(s_in);
		l = (64'(l_in) > ONE) ? ONE : 64'(l_in);
		// q and p carry 2*FRAC_BITS fraction bits
		if (2 * l < ONE) begin
			q2 = l * (ONE + s);
		end else begin
			q2 = (l + s) * ONE - l * s;
		end
		p2 = 2 * l * ONE - q2;
		h3 = 3 * h;
		pos_r = h3 + ONE;
		if (pos_r >= 3 * ONE) begin
			pos_r = pos_r - 3 * ONE;
		end
		pos_b = (h3 >= ONE) ? h3 - ONE : h3 + 2 * ONE;
		px.red = ramp_level(p2, q2, pos_r);
		px.green = ramp_level(p2, q2, h3);
		px.blue = ramp_level(p2, q2, pos_b);
		px.palette_index = CH_W'(16 + 36 * (px.red / 85) + 6 * (px.green / 85)
			+ px.blue / 85);
		return px;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		fails++;
		if (fails <= MAX_PRINTED) begin
			$display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_rgb_t want;
		if (!arst_n) begin
			expected_px_q.delete();
		end else begin
			if (hsl.valid && hsl.ready) begin
				expected_px_q.push_back(predict_pixel(hsl.hue, hsl.saturation,
					hsl.lightness));
			end
			if (rgb.valid && rgb.ready) begin
				if (expected_px_q.size() == 0) begin
					report_mismatch("unexpected word", int'(rgb.red), -1);
				end else begin
					want = expected_px_q.pop_front();
					checked++;
					if (rgb.red !== want.red)
						report_mismatch("red", int'(rgb.red), int'(want.red));
					if (rgb.green !== want.green)
						report_mismatch("green", int'(rgb.green), int'(want.green));
					if (rgb.blue !== want.blue)
						report_mismatch("blue", int'(rgb.blue), int'(want.blue));
					if (rgb.palette_index !== want.palette_index)
						report_mismatch("palette_index", int'(rgb.palette_index),
							int'(want.palette_index));
				end
			end
		end
		pending <= expected_px_q.size();
		fail_count <= fails;
		words_checked <= checked;
	end

endmodule

`default_nettype wire

// ----- tb/tb_hsl_to_rgb_palette_converter.sv -----
`default_nettype none

module tb_hsl_to_rgb_palette_converter;
	import hslrgb_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int ONE = 1 << FB;
	localparam int HALF = ONE / 2;
	localparam int RANDOM_PIXELS = 480;
	localparam int DRAIN_PAUSE_AT = 250;   // sender waits for an empty pipe here
	localparam int HOLD_AFTER = 150;       // sink holds off after this many words
	localparam int HOLD_CYCLES = 100;
	localparam int TAIL_CYCLES = 20;       // well past the depth of the five-stage pipeline

	logic clk;
	logic arst_n;

	int fail_count;
	int pending;
	int words_checked;
	int pixels_sent;
	int clamped_pixels;

	hslrgb_hsl_if #(.FRAC_BITS(FB)) hsl_bus ();
	hslrgb_rgb_if rgb_bus ();

	hsl_to_rgb_palette_converter #(.FRAC_BITS(FB)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsl    (hsl_bus),
		.rgb    (rgb_bus)
	);

	// watches both channels, predicts and compares
	hslrgb_checker #(.FRAC_BITS(FB)) chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.hsl           (hsl_bus),
		.rgb           (rgb_bus),
		.fail_count    (fail_count),
		.pending       (pending),
		.words_checked (words_checked)
	);

	// 10 unit clock, low first
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// mostly no gap, some short, a few long
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end else begin
			return $urandom_range(20, 60);
		end
	endfunction

	// saturation or lightness: mostly in range, some corners, some above one
	function automatic int unsigned pick_level();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			return $urandom_range(ONE + 1, 2 * ONE - 1);
		end else if (r < 4) begin
			case ($urandom_range(0, 3))
				0: return 0;
				1: return ONE;
				2: return HALF;
				default: return HALF - 1;
			endcase
		end else begin
			return $urandom_range(0, ONE);
		end
	endfunction

	// hue: mostly uniform, sometimes on a sixth-of-a-turn boundary
	function automatic int unsigned pick_hue();
		int unsigned k;
		if ($urandom_range(0, 7) == 0) begin
			k = $urandom_range(0, 5);
			return (k * ONE) / 6 + $urandom_range(0, 1);
		end
		return $urandom_range(0, ONE - 1);
	endfunction

	// offer one word and hold it until the block takes it
	task automatic send_pixel(
		input int unsigned h,
		input int unsigned s,
		input int unsigned l
	);
		hsl_bus.valid <= 1'b1;
		hsl_bus.hue <= FB'(h);
		hsl_bus.saturation <= (FB+1)'(s);
		hsl_bus.lightness <= (FB+1)'(l);
		do @(posedge clk); while (!hsl_bus.ready);
		pixels_sent++;
		if (s > ONE || l > ONE) begin
			clamped_pixels++;
		end
	endtask

	// idle the input for a random stretch unless in a calm run
	task automatic sender_gap(input bit calm);
		int unsigned n;
		n = calm ? 0 : gap_len();
		if (n != 0) begin
			hsl_bus.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// stop offering and wait until every expected word is back
	task automatic wait_for_drain();
		hsl_bus.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// output side: random stalls, one long hold-off while the sender keeps going
	initial begin
		bit calm;
		bit held_off;
		int unsigned n;
		calm = 1'b0;
		held_off = 1'b0;
		rgb_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 47) == 0) begin
				calm = !calm;
			end
			if (!held_off && words_checked >= HOLD_AFTER) begin
				held_off = 1'b1;
				rgb_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				n = calm ? 0 : gap_len();
				if (n != 0) begin
					rgb_bus.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
			rgb_bus.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// input side: reset, directed pixels, random pixels, verdict
	initial begin
		bit calm;
		int n;
		calm = 1'b0;
		pixels_sent = 0;
		clamped_pixels = 0;
		hsl_bus.valid = 1'b0;
		hsl_bus.hue = '0;
		hsl_bus.saturation = '0;
		hsl_bus.lightness = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// black, white and the field extremes
		send_pixel(0, 0, 0);               sender_gap(calm);
		send_pixel(0, 0, ONE);             sender_gap(calm);
		send_pixel(ONE - 1, ONE, ONE);     sender_gap(calm);
		send_pixel(ONE - 1, ONE, HALF);    sender_gap(calm);
		// fully saturated primaries and cyan
		send_pixel(0, ONE, HALF);          sender_gap(calm);
		send_pixel(1365, ONE, HALF);       sender_gap(calm);
		send_pixel(2731, ONE, HALF);       sender_gap(calm);
		send_pixel(2048, ONE, HALF);       sender_gap(calm);
		// ramp corners either side of a sixth of a turn
		send_pixel(682, ONE, HALF);        sender_gap(calm);
		send_pixel(683, ONE, HALF);        sender_gap(calm);
		send_pixel(3413, ONE, HALF);       sender_gap(calm);
		send_pixel(3414, ONE, HALF);       sender_gap(calm);
		// lightness just below and at one half picks the other q formula
		send_pixel(2500, ONE, HALF - 1);   sender_gap(calm);
		send_pixel(2500, 3000, HALF);      sender_gap(calm);
		send_pixel(3000, 2000, 1);         sender_gap(calm);
		send_pixel(3000, 2000, ONE - 1);   sender_gap(calm);
		// zero saturation gives grey
		send_pixel(1000, 0, HALF);         sender_gap(calm);
		send_pixel(1000, 0, 1234);         sender_gap(calm);
		// saturation and lightness above one are clamped
		send_pixel(ONE - 1, 2 * ONE - 1, 2 * ONE - 1); sender_gap(calm);
		send_pixel(200, ONE + 1, 1500);    sender_gap(calm);
		send_pixel(200, 3000, ONE + 1);    sender_gap(calm);
		send_pixel(777, 2 * ONE - 1, 0);   sender_gap(calm);

		// random pixels with calm runs mixed in
		for (n = 0; n < RANDOM_PIXELS; n++) begin
			if ($urandom_range(0, 47) == 0) begin
				calm = !calm;
			end
			if (n == DRAIN_PAUSE_AT) begin
				wait_for_drain();
			end
			send_pixel(pick_hue(), pick_level(), pick_level());
			sender_gap(calm);
		end

		// let the pipeline empty, then wait out TAIL_CYCLES for strays
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run: %0d pixels in (22 directed), %0d results compared, %0d clamped",
			pixels_sent, words_checked, clamped_pixels);
		$display("run: random stalls both sides, one %0d-cycle output hold, one drain pause",
			HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
